// ----- rtl/dmf_pkg.sv -----
// Shared widths, constants, types and helpers for the dipole field pipeline.
package dmf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_W  = 32;
    localparam int OUT_W = 48;
    localparam int QB    = 49;            // magnitude bits searched: 48 down to 0

    localparam int RW    = IN_W + 1;      // |r| component
    localparam int MW    = IN_W;          // |m| component
    localparam int DW    = 2 * IN_W + 3;  // |3 (m.r)|
    localparam int SW    = 2 * IN_W + 2;  // |r|^2
    localparam int AW    = DW + RW;       // |3 (m.r) r_i|
    localparam int BW    = SW + MW;       // | |r|^2 m_i |
    localparam int NW    = AW + 1;        // |N_i|
    localparam int NNW   = 2 * NW;        // N_i^2
    localparam int SSW   = 2 * SW;        // s^2
    localparam int S4W   = 4 * SW;        // s^4
    localparam int S5W   = 5 * SW;        // s^5

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } t_side;

    // Pipeline depth of the partial-product multiplier: one register stage for the 32x32
    // products, then one register stage per level of the adder tree.
    function automatic int mul_lat(input int aw, input int bw);
        int np;
        np = ((aw + 31) / 32) * ((bw + 31) / 32);
        return 1 + $clog2(np);
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/dmf_dly.sv -----
// Enabled delay line of D register stages (D may be zero).
module dmf_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    if (D == 0) begin : g_wire
        assign o_q = i_d;
    end else begin : g_regs
        logic [W-1:0] r_sh [0:D-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[0] <= i_d;
                for (int k = 1; k < D; k++) begin
                    r_sh[k] <= r_sh[k-1];
                end
            end
        end

        assign o_q = r_sh[D-1];
    end

endmodule

// ----- rtl/dmf_mul.sv -----
// Pipelined unsigned multiplier: registered 32x32 partial products, registered adder tree.
module dmf_mul #(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int LAT = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NA  = (AW + 31) / 32;
    localparam int NB  = (BW + 31) / 32;
    localparam int NP  = NA * NB;
    localparam int LV  = $clog2(NP);
    localparam int PW  = AW + BW;
    localparam int PAD = LAT - 1 - LV;

    logic [NA*32-1:0] w_a;
    logic [NB*32-1:0] w_b;
    logic [PW-1:0]    w_pp   [0:NP-1];
    logic [PW-1:0]    r_lvl  [0:LV][0:NP-1];

    assign w_a = (NA*32)'(i_a);
    assign w_b = (NB*32)'(i_b);

    // partials are aligned to their weight; each fits since chunk <= operand
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                w_pp[i*NB+j] = PW'((PW+64)'(64'(w_a[i*32+:32]) * 64'(w_b[j*32+:32]))
                                   << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < NP; p++) begin
                r_lvl[0][p] <= w_pp[p];
            end
            for (int k = 1; k <= LV; k++) begin
                for (int e = 0; e < NP; e++) begin
                    if (e < ((NP + (1 << k) - 1) >> k)) begin
                        if ((2*e + 1 < NP) &&
                            (2*e + 1 < ((NP + (1 << (k-1)) - 1) >> (k-1)))) begin
                            r_lvl[k][e] <= r_lvl[k-1][2*e] + r_lvl[k-1][2*e+1];
                        end else begin
                            r_lvl[k][e] <= r_lvl[k-1][2*e];
                        end
                    end else begin
                        r_lvl[k][e] <= '0;
                    end
                end
            end
        end
    end

    dmf_dly #(.W(PW), .D(PAD)) u_pad (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_lvl[LV][0]),
        .o_q   (o_p)
    );

endmodule

// ----- rtl/dmf_root_stage.sv -----
// One bit of the magnitude search q^2 s^5 <= N^2 2^(6F), three lanes sharing s^5.
module dmf_root_stage #(
    parameter int BIT = 0,
    parameter int TW  = 298,
    parameter int S5W = dmf_pkg::S5W
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [S5W-1:0]               i_s5,
    input  logic [2:0][TW-1:0]           i_rem,
    input  logic [2:0][TW-1:0]           i_qs,
    input  logic [2:0][dmf_pkg::QB-1:0]  i_q,
    input  dmf_pkg::t_side               i_side,
    output logic [S5W-1:0]               o_s5,
    output logic [2:0][TW-1:0]           o_rem,
    output logic [2:0][TW-1:0]           o_qs,
    output logic [2:0][dmf_pkg::QB-1:0]  o_q,
    output dmf_pkg::t_side               o_side
);

    localparam int QB = dmf_pkg::QB;
    localparam int XW = S5W + 2*BIT + TW + 1;

    logic [XW-1:0]        w_s2b;
    logic [XW-1:0]        w_s1b;
    logic                 w_big;
    logic [2:0][TW:0]     w_term;
    logic [2:0]           w_take;

    logic [S5W-1:0]              r_s5;
    logic [2:0][TW-1:0]          r_rem;
    logic [2:0][TW-1:0]          r_qs;
    logic [2:0][QB-1:0]          r_q;
    dmf_pkg::t_side              r_side;

    assign w_s2b = XW'(i_s5) << (2*BIT);
    assign w_s1b = XW'(i_s5) << BIT;
    // s^5 2^(2b) beyond the residual width can never fit
    assign w_big = |w_s2b[XW-1:TW];

    // (q + 2^b)^2 s5 - q^2 s5 = 2^(b+1) q s5 + 2^(2b) s5
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_term[l] = (TW+1)'(w_s2b[TW-1:0]) + ((TW+1)'(i_qs[l]) << (BIT+1));
            w_take[l] = !w_big && (w_term[l] <= (TW+1)'(i_rem[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5   <= i_s5;
            r_side <= i_side;
            for (int l = 0; l < 3; l++) begin
                if (w_take[l]) begin
                    r_rem[l] <= i_rem[l] - w_term[l][TW-1:0];
                    r_qs[l]  <= i_qs[l] + w_s1b[TW-1:0];
                    r_q[l]   <= i_q[l] | (QB'(1) << BIT);
                end else begin
                    r_rem[l] <= i_rem[l];
                    r_qs[l]  <= i_qs[l];
                    r_q[l]   <= i_q[l];
                end
            end
        end
    end

    assign o_s5   = r_s5;
    assign o_rem  = r_rem;
    assign o_qs   = r_qs;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

// ----- rtl/dipole_magnetic_field.sv -----
// Top level: pipelined point-dipole magnetic field evaluator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | i_valid / o_ready  | observer, dipole, moment (x,y,z), Q16.16
//  output  | out       | o_valid / i_ready  | field x,y,z (48b), zero_distance, saturated
//
// One transaction enters per cycle unless the pipeline is stalled; at the default widths every result
// crosses 4 + three multiplier groups + 3 + 49 search stages + 1 output register.
// The 49-stage magnitude search, one result bit per stage, sets the depth.
// The whole pipeline advances together; when the output register holds an
// untaken result, every stage freezes and o_ready drops, so nothing is lost.
// Reset (i_rst_n low, synchronous) clears only the valid bits.
module dipole_magnetic_field #(
    parameter int FRAC_BITS = dmf_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_observer_x,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_observer_y,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_observer_z,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_dipole_x,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_dipole_y,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_dipole_z,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_moment_x,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_moment_y,
    input  logic signed [dmf_pkg::IN_W-1:0]   i_moment_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [dmf_pkg::OUT_W-1:0]  o_field_x,
    output logic signed [dmf_pkg::OUT_W-1:0]  o_field_y,
    output logic signed [dmf_pkg::OUT_W-1:0]  o_field_z,
    output logic                              o_zero_distance,
    output logic                              o_saturated
);

    localparam int IN_W  = dmf_pkg::IN_W;
    localparam int OUT_W = dmf_pkg::OUT_W;
    localparam int QB    = dmf_pkg::QB;
    localparam int RW    = dmf_pkg::RW;
    localparam int MW    = dmf_pkg::MW;
    localparam int DW    = dmf_pkg::DW;
    localparam int SW    = dmf_pkg::SW;
    localparam int AW    = dmf_pkg::AW;
    localparam int BW    = dmf_pkg::BW;
    localparam int NW    = dmf_pkg::NW;
    localparam int NNW   = dmf_pkg::NNW;
    localparam int SSW   = dmf_pkg::SSW;
    localparam int S4W   = dmf_pkg::S4W;
    localparam int S5W   = dmf_pkg::S5W;

    // residual width: N^2 scaled by 2^(6F)
    localparam int TW    = NNW + 6*FRAC_BITS;

    localparam int LAT1  = dmf_pkg::max_int(dmf_pkg::mul_lat(DW, RW),
                           dmf_pkg::max_int(dmf_pkg::mul_lat(SW, MW),
                                            dmf_pkg::mul_lat(SW, SW)));
    localparam int LAT2  = dmf_pkg::max_int(dmf_pkg::mul_lat(NW, NW),
                                            dmf_pkg::mul_lat(SSW, SSW));
    localparam int LAT3  = dmf_pkg::mul_lat(S4W, SW);
    localparam int SDW   = $bits(dmf_pkg::t_side);

    // valid bits for every register stage ahead of the output register
    localparam int NV    = 4 + LAT1 + 3 + LAT2 + LAT3 + QB;

    // ---------------------------------------------------------------- control
    logic          w_en;
    logic [NV-1:0] r_vld;
    logic          r_ovld;

    // Whole pipeline moves when the output slot is empty or being drained.
    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[NV-2:0], i_valid};
            r_ovld <= r_vld[NV-1];
        end
    end

    // ---------------------------------------------------------------- inputs
    logic signed [IN_W-1:0] w_obs [0:2];
    logic signed [IN_W-1:0] w_dip [0:2];
    logic signed [IN_W-1:0] w_mom [0:2];

    assign w_obs[0] = i_observer_x;
    assign w_obs[1] = i_observer_y;
    assign w_obs[2] = i_observer_z;
    assign w_dip[0] = i_dipole_x;
    assign w_dip[1] = i_dipole_y;
    assign w_dip[2] = i_dipole_z;
    assign w_mom[0] = i_moment_x;
    assign w_mom[1] = i_moment_y;
    assign w_mom[2] = i_moment_z;

    // ------------------------------------------------- stages 1..3: r, m.r, s
    logic signed [RW-1:0]     r_r1  [0:2];
    logic signed [IN_W-1:0]   r_m1  [0:2];
    logic signed [2*IN_W:0]   r_pm2 [0:2];    // m_i r_i
    logic signed [SW-1:0]     r_pr2 [0:2];    // r_i^2
    logic signed [RW-1:0]     r_r2  [0:2];
    logic signed [IN_W-1:0]   r_m2  [0:2];
    logic signed [DW-1:0]     r_dot3;
    logic        [SW-1:0]     r_s3;
    logic signed [RW-1:0]     r_r3  [0:2];
    logic signed [IN_W-1:0]   r_m3  [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_r1[l]  <= RW'(w_obs[l]) - RW'(w_dip[l]);
                r_m1[l]  <= w_mom[l];
                r_pm2[l] <= (2*IN_W+1)'(r_r1[l]) * (2*IN_W+1)'(r_m1[l]);
                r_pr2[l] <= SW'(r_r1[l]) * SW'(r_r1[l]);
                r_r2[l]  <= r_r1[l];
                r_m2[l]  <= r_m1[l];
                r_r3[l]  <= r_r2[l];
                r_m3[l]  <= r_m2[l];
            end
            r_dot3 <= DW'(r_pm2[0]) + DW'(r_pm2[1]) + DW'(r_pm2[2]);
            r_s3   <= SW'($unsigned(r_pr2[0])) + SW'($unsigned(r_pr2[1]))
                    + SW'($unsigned(r_pr2[2]));
        end
    end

    // ------------------------------------- stage 4: magnitudes and signs
    logic signed [DW+1:0] w_d3;
    logic signed [DW+1:0] w_d3a;
    logic signed [RW:0]   w_ra [0:2];
    logic signed [MW:0]   w_ma [0:2];

    logic [DW-1:0] r_ad4;
    logic          r_nd4;
    logic [RW-1:0] r_ar4 [0:2];
    logic [2:0]    r_nr4;
    logic [MW-1:0] r_am4 [0:2];
    logic [2:0]    r_nm4;
    logic [SW-1:0] r_s4;
    logic          r_z4;

    always_comb begin
        w_d3  = (DW+2)'(r_dot3) + ((DW+2)'(r_dot3) <<< 1);
        w_d3a = w_d3[DW+1] ? -w_d3 : w_d3;
        for (int l = 0; l < 3; l++) begin
            w_ra[l] = r_r3[l][RW-1] ? -(RW+1)'(r_r3[l]) : (RW+1)'(r_r3[l]);
            w_ma[l] = r_m3[l][MW-1] ? -(MW+1)'(r_m3[l]) : (MW+1)'(r_m3[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ad4 <= w_d3a[DW-1:0];
            r_nd4 <= w_d3[DW+1];
            for (int l = 0; l < 3; l++) begin
                r_ar4[l] <= w_ra[l][RW-1:0];
                r_nr4[l] <= r_r3[l][RW-1];
                r_am4[l] <= w_ma[l][MW-1:0];
                r_nm4[l] <= r_m3[l][MW-1];
            end
            r_s4 <= r_s3;
            r_z4 <= (r_s3 == '0);
        end
    end

    // ---------------- group 1: |3(m.r)| |r_i|, s |m_i|, s^2
    logic [AW-1:0]  w_pa  [0:2];
    logic [BW-1:0]  w_pb  [0:2];
    logic [SSW-1:0] w_ss;
    logic [6:0]     w_g1s_in;
    logic [6:0]     w_g1s;
    logic [SW-1:0]  w_s_g3;
    logic [SSW-1:0] w_ss7;

    for (genvar l = 0; l < 3; l++) begin : g_g1
        dmf_mul #(.AW(DW), .BW(RW), .LAT(LAT1)) u_mul_a (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (r_ad4), .i_b (r_ar4[l]), .o_p (w_pa[l])
        );
        dmf_mul #(.AW(SW), .BW(MW), .LAT(LAT1)) u_mul_b (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (r_s4), .i_b (r_am4[l]), .o_p (w_pb[l])
        );
    end

    dmf_mul #(.AW(SW), .BW(SW), .LAT(LAT1)) u_mul_ss (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_s4), .i_b (r_s4), .o_p (w_ss)
    );

    // {zero, sign of A per lane, sign of B per lane}
    assign w_g1s_in = {r_z4, r_nr4 ^ {3{r_nd4}}, r_nm4};

    dmf_dly #(.W(7), .D(LAT1)) u_dly_g1 (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_g1s_in), .o_q (w_g1s)
    );

    // s rides along until s^4 is ready for the last multiply
    dmf_dly #(.W(SW), .D(LAT1 + 3 + LAT2)) u_dly_s (
        .i_clk (i_clk), .i_en (w_en), .i_d (r_s4), .o_q (w_s_g3)
    );

    dmf_dly #(.W(SSW), .D(3)) u_dly_ss (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_ss), .o_q (w_ss7)
    );

    // --------------- stages 5..7: N_i = 3(m.r) r_i - s m_i, then |N_i|
    logic signed [NW:0]  r_sa5 [0:2];
    logic signed [NW:0]  r_sb5 [0:2];
    logic                r_z5;
    logic signed [NW:0]  r_n6  [0:2];
    logic                r_z6;
    logic [NW-1:0]       r_an7 [0:2];
    logic [2:0]          r_nn7;
    logic                r_z7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_sa5[l] <= w_g1s[3+l] ? -$signed((NW+1)'(w_pa[l]))
                                       :  $signed((NW+1)'(w_pa[l]));
                r_sb5[l] <= w_g1s[l]   ? -$signed((NW+1)'(w_pb[l]))
                                       :  $signed((NW+1)'(w_pb[l]));
                r_n6[l]  <= r_sa5[l] - r_sb5[l];
                r_an7[l] <= NW'(r_n6[l][NW] ? -r_n6[l] : r_n6[l]);
                r_nn7[l] <= r_n6[l][NW];
            end
            r_z5 <= w_g1s[6];
            r_z6 <= r_z5;
            r_z7 <= r_z6;
        end
    end

    // ---------------- groups 2 and 3: N_i^2, s^4, s^5
    logic [NNW-1:0] w_nn  [0:2];
    logic [NNW-1:0] w_nn3 [0:2];
    logic [S4W-1:0] w_sq4;
    logic [S5W-1:0] w_s5;
    dmf_pkg::t_side w_side7;
    logic [SDW-1:0] w_side_rt;

    for (genvar l = 0; l < 3; l++) begin : g_g2
        dmf_mul #(.AW(NW), .BW(NW), .LAT(LAT2)) u_mul_nn (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (r_an7[l]), .i_b (r_an7[l]), .o_p (w_nn[l])
        );
        dmf_dly #(.W(NNW), .D(LAT3)) u_dly_nn (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_nn[l]), .o_q (w_nn3[l])
        );
    end

    dmf_mul #(.AW(SSW), .BW(SSW), .LAT(LAT2)) u_mul_s4 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_ss7), .i_b (w_ss7), .o_p (w_sq4)
    );

    dmf_mul #(.AW(S4W), .BW(SW), .LAT(LAT3)) u_mul_s5 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_sq4), .i_b (w_s_g3), .o_p (w_s5)
    );

    assign w_side7.zero = r_z7;
    assign w_side7.neg  = r_nn7;

    dmf_dly #(.W(SDW), .D(LAT2 + LAT3)) u_dly_side (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_side7), .o_q (w_side_rt)
    );

    // ---------------- magnitude search, one bit per stage, MSB first.
    // q is the largest value with q^2 s^5 <= N^2 2^(6F), i.e. the field
    // magnitude truncated toward zero.
    logic [S5W-1:0]         w_s5c [0:QB];
    logic [2:0][TW-1:0]     w_rem [0:QB];
    logic [2:0][TW-1:0]     w_qs  [0:QB];
    logic [2:0][QB-1:0]     w_q   [0:QB];
    dmf_pkg::t_side         w_sd  [0:QB];

    assign w_s5c[0] = w_s5;
    assign w_sd[0]  = dmf_pkg::t_side'(w_side_rt);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_rem[0][l] = TW'(w_nn3[l]) << (6*FRAC_BITS);
            w_qs[0][l]  = '0;
            w_q[0][l]   = '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_root
        dmf_root_stage #(.BIT(QB-1-k), .TW(TW), .S5W(S5W)) u_stage (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_s5   (w_s5c[k]),
            .i_rem  (w_rem[k]),
            .i_qs   (w_qs[k]),
            .i_q    (w_q[k]),
            .i_side (w_sd[k]),
            .o_s5   (w_s5c[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_qs   (w_qs[k+1]),
            .o_q    (w_q[k+1]),
            .o_side (w_sd[k+1])
        );
    end

    // ---------------- sign, clamp, zero override, output register
    logic [OUT_W-1:0] w_val [0:2];
    logic [2:0]       w_sat;
    logic [OUT_W-1:0] r_fld [0:2];
    logic             r_zero;
    logic             r_sat;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (w_sd[QB].zero) begin
                w_sat[l] = 1'b0;
                w_val[l] = '0;
            end else if (w_sd[QB].neg[l]) begin
                // -2^47 is still representable
                w_sat[l] = w_q[QB][l][QB-1] ||
                           (w_q[QB][l][OUT_W-1] && (|w_q[QB][l][OUT_W-2:0]));
                w_val[l] = w_sat[l] ? dmf_pkg::OUT_MIN : -OUT_W'(w_q[QB][l]);
            end else begin
                w_sat[l] = |w_q[QB][l][QB-1:OUT_W-1];
                w_val[l] = w_sat[l] ? dmf_pkg::OUT_MAX : OUT_W'(w_q[QB][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_fld[l] <= w_val[l];
            end
            r_zero <= w_sd[QB].zero;
            r_sat  <= |w_sat;
        end
    end

    assign o_field_x       = r_fld[0];
    assign o_field_y       = r_fld[1];
    assign o_field_z       = r_fld[2];
    assign o_zero_distance = r_zero;
    assign o_saturated     = r_sat;

`ifndef SYNTHESIS
    a_zero_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_distance) |->
            (o_field_x == '0 && o_field_y == '0 && o_field_z == '0 && !o_saturated))
        else $error("zero separation result carries a nonzero field or saturation");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_field_x == dmf_pkg::OUT_MAX || o_field_x == dmf_pkg::OUT_MIN ||
             o_field_y == dmf_pkg::OUT_MAX || o_field_y == dmf_pkg::OUT_MIN ||
             o_field_z == dmf_pkg::OUT_MAX || o_field_z == dmf_pkg::OUT_MIN))
        else $error("saturation flagged but no component is at a rail");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vld) && $stable(r_ovld)))
        else $error("pipeline valid bits moved during a stall");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the first stage");
`endif

endmodule

// ----- test/dipole_magnetic_field_tb.sv -----
// Self-checking testbench for the dipole_magnetic_field pipeline.
`timescale 1ns / 100ps

module dipole_magnetic_field_tb;

    localparam int IN_W      = dmf_pkg::IN_W;
    localparam int OUT_W     = dmf_pkg::OUT_W;
    localparam int QB        = dmf_pkg::QB;
    localparam logic [OUT_W-1:0] OUT_MAX = dmf_pkg::OUT_MAX;
    localparam logic [OUT_W-1:0] OUT_MIN = dmf_pkg::OUT_MIN;

    localparam int FB        = dmf_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1030;
    localparam int STALL_MAX = 5000;   // cycles with no transaction on either side
    localparam int DRAIN     = 120;    // pipeline is 74 deep

    typedef struct {
        logic signed [IN_W-1:0] obs [3];
        logic signed [IN_W-1:0] dip [3];
        logic signed [IN_W-1:0] mom [3];
    } t_point;

    typedef struct {
        logic signed [OUT_W-1:0] b [3];
        logic                    zero;
        logic                    sat;
    } t_field;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic signed [IN_W-1:0]  obs_d [3], dip_d [3], mom_d [3];
    logic signed [OUT_W-1:0] o_field_x, o_field_y, o_field_z;
    logic o_zero_distance, o_saturated;

    t_point pending_points[$];
    t_field expected_fields[$];
    t_point cur_point;
    int     snd_idle_pct, rcv_idle_pct;
    int     n_sent, n_errors, quiet_cycles;
    bit     taken, finished;

    dipole_magnetic_field u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_observer_x(obs_d[0]), .i_observer_y(obs_d[1]), .i_observer_z(obs_d[2]),
        .i_dipole_x(dip_d[0]), .i_dipole_y(dip_d[1]), .i_dipole_z(dip_d[2]),
        .i_moment_x(mom_d[0]), .i_moment_y(mom_d[1]), .i_moment_z(mom_d[2]),
        .o_valid, .i_ready, .o_field_x, .o_field_y, .o_field_z,
        .o_zero_distance, .o_saturated
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // One axis of the field: trunc(|N| 2^(3F) / |r|^5) found as the largest q
    // with q^2 s^5 <= N^2 2^(6F), then clamped to the 48-bit range.
    function automatic logic signed [OUT_W-1:0] axis_field(
        input logic signed [127:0] dot3, ri, s, mi,
        input logic [511:0] s5, inout logic sat);
        logic signed [127:0] n;
        logic [511:0] nn, quo, cand, q;
        logic neg;
        n   = dot3 * ri - s * mi;
        neg = n < 0;
        if (neg) n = -n;
        nn  = 512'(n);
        nn  = (nn * nn) << (6 * FB);
        quo = nn / s5;
        q   = '0;
        for (int b = QB - 1; b >= 0; b--) begin
            cand = q | (512'(1) << b);
            if (cand * cand <= quo) q = cand;
        end
        if (!neg) begin
            if (q > 512'(OUT_MAX)) begin
                sat = 1'b1;
                return OUT_MAX;
            end
            return OUT_W'(q);
        end
        if (q > (512'(1) << (OUT_W - 1))) begin
            sat = 1'b1;
            return OUT_MIN;
        end
        return OUT_W'(-q);
    endfunction

    function automatic t_field dipole_field(input t_point p);
        t_field f;
        logic signed [127:0] r [3], m [3], dot, s;
        logic [511:0] s5;
        dot = 0;
        s   = 0;
        for (int i = 0; i < 3; i++) begin
            r[i] = 128'(p.obs[i]) - 128'(p.dip[i]);
            m[i] = 128'(p.mom[i]);
            dot += m[i] * r[i];
            s   += r[i] * r[i];
        end
        f.zero = (s == 0);
        f.sat  = 1'b0;
        for (int i = 0; i < 3; i++) f.b[i] = '0;
        if (f.zero) return f;
        s5 = 512'(s);
        s5 = s5 * s5 * s5 * s5 * s5;
        for (int i = 0; i < 3; i++)
            f.b[i] = axis_field(3 * dot, r[i], s, m[i], s5, f.sat);
        return f;
    endfunction

    // Signed value with a random magnitude of up to 'bits' bits.
    function automatic logic signed [IN_W-1:0] rand_span(input int bits);
        logic signed [IN_W-1:0] v;
        v = $urandom;
        return v >>> (IN_W - bits);
    endfunction

    function automatic t_point make_point(input int mode);
        t_point p;
        int sh;
        sh = $urandom_range(1, 32);
        for (int i = 0; i < 3; i++) begin
            p.dip[i] = $urandom;
            p.mom[i] = (mode == 3) ? rand_span(32) : rand_span($urandom_range(1, 32));
            case (mode)
                0: p.obs[i] = $urandom;
                1: p.obs[i] = p.dip[i] + rand_span(sh);
                2: p.obs[i] = p.dip[i];
                default: p.obs[i] = p.dip[i] + rand_span($urandom_range(1, 4));
            endcase
        end
        return p;
    endfunction

    task automatic push_point(input logic signed [IN_W-1:0] o, d, m, input int axis);
        t_point p;
        for (int i = 0; i < 3; i++) begin
            p.obs[i] = 0;
            p.dip[i] = 0;
            p.mom[i] = 0;
        end
        p.obs[axis] = o;
        p.dip[axis] = d;
        p.mom[axis] = m;
        pending_points.push_back(p);
    endtask

    // Driver: new transaction presented at the falling edge, held until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || taken) begin
            if (pending_points.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                cur_point = pending_points.pop_front();
                obs_d   <= cur_point.obs;
                dip_d   <= cur_point.dip;
                mom_d   <= cur_point.mom;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        taken = 1'b0;
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Input side: prediction made when the block takes the transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_fields.push_back(dipole_field(cur_point));
            taken = 1'b1;
            n_sent++;
        end
    end

    // Monitor: every result checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_field want;
        logic signed [OUT_W-1:0] got [3];
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_field_x, o_field_y, o_field_z};
            if (expected_fields.size() == 0) begin
                $error("result with no transaction outstanding");
                n_errors++;
            end else begin
                want = expected_fields.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got[i] !== want.b[i]) begin
                        $error("field_%s expected %0d actual %0d",
                               (i == 0) ? "x" : (i == 1) ? "y" : "z", want.b[i], got[i]);
                        n_errors++;
                    end
                if (o_zero_distance !== want.zero) begin
                    $error("zero_distance expected %0b actual %0b", want.zero, o_zero_distance);
                    n_errors++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated expected %0b actual %0b", want.sat, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: any cycle without a transaction counts toward the limit until the run is finished.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || finished) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("dipole_magnetic_field verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int mode;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        for (int i = 0; i < 3; i++) begin
            obs_d[i] = 0;
            dip_d[i] = 0;
            mom_d[i] = 0;
        end
        n_sent = 0;
        n_errors = 0;
        quiet_cycles = 0;
        taken = 1'b0;
        finished = 1'b0;
        snd_idle_pct = 38;
        rcv_idle_pct = 85;

        // Directed: zero separation, field extremes, saturation, sign corners.
        push_point(0, 0, 0, 0);
        push_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
        push_point(32'sh00010000, 0, 32'sh00010000, 0);
        push_point(32'sh00010000, 0, -32'sh00010000, 2);
        push_point(1, 0, 32'sh7fffffff, 0);
        push_point(1, 0, 32'sh80000000, 1);
        push_point(-1, 0, 32'sh7fffffff, 2);
        push_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        push_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1);
        push_point(32'sh7fffffff, 32'sh80000000, 1, 2);
        push_point(32'sh00010000, 0, 0, 0);
        push_point(-32'sh00020000, 32'sh00010000, 32'sh00030000, 1);
        push_point(32'shffffffff, 0, 32'sh00000001, 2);
        for (int k = 0; k < 7; k++) pending_points.push_back(make_point(k % 4));
        for (int k = 0; k < N_RANDOM; k++) begin
            mode = $urandom_range(0, 99);
            pending_points.push_back(make_point(mode < 30 ? 0 : mode < 75 ? 1 :
                                                mode < 83 ? 2 : 3));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        wait (n_sent >= 350);
        snd_idle_pct = 85;
        rcv_idle_pct = 38;
        wait (n_sent >= 700);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;

        wait (pending_points.size() == 0 && !i_valid && expected_fields.size() == 0);
        finished = 1'b1;
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0 && expected_fields.size() == 0)
            $display("dipole_magnetic_field verification clean");
        else
            $display("dipole_magnetic_field verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dmf_pkg.sv
rtl/dmf_dly.sv
rtl/dmf_mul.sv
rtl/dmf_root_stage.sv
rtl/dipole_magnetic_field.sv
test/dipole_magnetic_field_tb.sv
